>>> hw/rtl/ubxfr_pkg.sv
// Shared types and constants for the UBX frame receiver.
// No dependencies; used by all modules in hw/rtl.
package ubxfr_pkg;

    // Register map indexes (byte address = 4 * index)
    localparam int unsigned CFG_ADDR_W = 4;
    typedef enum logic [1:0] {
        REG_SYNC_FIRST  = 2'd0,
        REG_SYNC_SECOND = 2'd1,
        REG_MAX_LEN     = 2'd2,
        REG_UNUSED      = 2'd3
    } reg_idx_t;

    // Reset values of the configuration registers
    localparam logic [7:0]  SYNC_FIRST_RST  = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'h62;
    localparam logic [15:0] MAX_LEN_RST     = 16'd512;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_GOOD     = 2'd1,
        KIND_BAD_SUM  = 2'd2,
        KIND_TOO_LONG = 2'd3
    } kind_t;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HUNT1   = 3'd0,
        PH_HUNT2   = 3'd1,
        PH_HEADER  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CK_A    = 3'd4,
        PH_CK_B    = 3'd5
    } phase_t;

    // Configuration handed from the register block to the parser
    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [15:0] max_payload_len;
    } cfg_t;

endpackage

>>> hw/rtl/ubxfr_regs.sv
// APB-style configuration registers of the UBX frame receiver.
// Depends on ubxfr_pkg.
module ubxfr_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ubxfr_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output ubxfr_pkg::cfg_t                   cfg
);

    ubxfr_pkg::cfg_t  cfg_reg;
    ubxfr_pkg::reg_idx_t idx;
    logic             wr_en;

    assign idx    = ubxfr_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register writes in the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_first      <= ubxfr_pkg::SYNC_FIRST_RST;
            cfg_reg.sync_second     <= ubxfr_pkg::SYNC_SECOND_RST;
            cfg_reg.max_payload_len <= ubxfr_pkg::MAX_LEN_RST;
        end else if (wr_en) begin
            unique case (idx)
                ubxfr_pkg::REG_SYNC_FIRST:  cfg_reg.sync_first      <= pwdata[7:0];
                ubxfr_pkg::REG_SYNC_SECOND: cfg_reg.sync_second     <= pwdata[7:0];
                ubxfr_pkg::REG_MAX_LEN:     cfg_reg.max_payload_len <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (idx)
            ubxfr_pkg::REG_SYNC_FIRST:  prdata = {24'd0, cfg_reg.sync_first};
            ubxfr_pkg::REG_SYNC_SECOND: prdata = {24'd0, cfg_reg.sync_second};
            ubxfr_pkg::REG_MAX_LEN:     prdata = {16'd0, cfg_reg.max_payload_len};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

>>> hw/rtl/ubxfr_parser.sv
// Byte-stream frame parser: input register, phase FSM, Fletcher sums and
// result register. Depends on ubxfr_pkg.
module ubxfr_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  ubxfr_pkg::cfg_t   cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_rx_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_kind,
    output logic [7:0]        m_data,
    output logic [7:0]        m_msg_class,
    output logic [7:0]        m_msg_id,
    output logic [15:0]       m_payload_len,
    output logic [15:0]       m_payload_index
);

    // Input stage
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        fire;

    // Parser state
    ubxfr_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  header_count_reg, header_count_next;
    logic [7:0]  frame_class_reg, frame_class_next;
    logic [7:0]  frame_id_reg, frame_id_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic [15:0] payload_count_reg, payload_count_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  rx_sum_a_reg, rx_sum_a_next;

    // Result stage
    logic        out_valid_reg;
    ubxfr_pkg::kind_t out_kind_reg;
    logic [7:0]  out_data_reg, out_class_reg, out_id_reg;
    logic [15:0] out_len_reg, out_index_reg;

    // Per-byte datapath
    logic [7:0]  b;
    logic [7:0]  sum_a_add, sum_b_add;
    logic [15:0] len_full, count_inc;
    logic        len_over;
    logic        emit;
    ubxfr_pkg::kind_t emit_kind;
    logic [7:0]  emit_data;
    logic [15:0] emit_index;

    assign b         = in_byte_reg;
    assign sum_a_add = sum_a_reg + b;
    assign sum_b_add = sum_b_reg + sum_a_add;
    assign len_full  = {b, frame_length_reg[7:0]};
    assign len_over  = len_full > cfg.max_payload_len;
    assign count_inc = payload_count_reg + 16'd1;

    // Byte is processed when the result register can take its outcome
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        if (fire) begin
            unique case (phase_reg)
                ubxfr_pkg::PH_HUNT1:
                    phase_next = (b == cfg.sync_first) ? ubxfr_pkg::PH_HUNT2
                                                       : ubxfr_pkg::PH_HUNT1;
                ubxfr_pkg::PH_HUNT2:
                    phase_next = (b == cfg.sync_second) ? ubxfr_pkg::PH_HEADER
                                                        : ubxfr_pkg::PH_HUNT1;
                ubxfr_pkg::PH_HEADER: begin
                    if (header_count_reg == 2'd3) begin
                        if (len_over)
                            phase_next = ubxfr_pkg::PH_HUNT1;
                        else if (len_full == 16'd0)
                            phase_next = ubxfr_pkg::PH_CK_A;
                        else
                            phase_next = ubxfr_pkg::PH_PAYLOAD;
                    end
                end
                ubxfr_pkg::PH_PAYLOAD:
                    if (count_inc >= frame_length_reg) phase_next = ubxfr_pkg::PH_CK_A;
                ubxfr_pkg::PH_CK_A: phase_next = ubxfr_pkg::PH_CK_B;
                ubxfr_pkg::PH_CK_B: phase_next = ubxfr_pkg::PH_HUNT1;
                default:            phase_next = ubxfr_pkg::PH_HUNT1;
            endcase
        end
    end

    // Frame fields, sums and result selection
    always_comb begin
        header_count_next  = header_count_reg;
        frame_class_next   = frame_class_reg;
        frame_id_next      = frame_id_reg;
        frame_length_next  = frame_length_reg;
        payload_count_next = payload_count_reg;
        sum_a_next         = sum_a_reg;
        sum_b_next         = sum_b_reg;
        rx_sum_a_next      = rx_sum_a_reg;
        emit               = 1'b0;
        emit_kind          = ubxfr_pkg::KIND_PAYLOAD;
        emit_data          = 8'd0;
        emit_index         = 16'd0;
        if (fire) begin
            unique case (phase_reg)
                ubxfr_pkg::PH_HUNT2: begin
                    if (b == cfg.sync_second) begin
                        header_count_next = 2'd0;
                        sum_a_next        = 8'd0;
                        sum_b_next        = 8'd0;
                    end
                end
                ubxfr_pkg::PH_HEADER: begin
                    sum_a_next = sum_a_add;
                    sum_b_next = sum_b_add;
                    unique case (header_count_reg)
                        2'd0: begin
                            frame_class_next  = b;
                            header_count_next = 2'd1;
                        end
                        2'd1: begin
                            frame_id_next     = b;
                            header_count_next = 2'd2;
                        end
                        2'd2: begin
                            frame_length_next = {8'd0, b};
                            header_count_next = 2'd3;
                        end
                        default: begin
                            frame_length_next  = len_full;
                            header_count_next  = 2'd0;
                            payload_count_next = 16'd0;
                            if (len_over) begin
                                emit      = 1'b1;
                                emit_kind = ubxfr_pkg::KIND_TOO_LONG;
                            end
                        end
                    endcase
                end
                ubxfr_pkg::PH_PAYLOAD: begin
                    sum_a_next         = sum_a_add;
                    sum_b_next         = sum_b_add;
                    payload_count_next = count_inc;
                    emit               = 1'b1;
                    emit_kind          = ubxfr_pkg::KIND_PAYLOAD;
                    emit_data          = b;
                    emit_index         = payload_count_reg;
                end
                ubxfr_pkg::PH_CK_A: rx_sum_a_next = b;
                ubxfr_pkg::PH_CK_B: begin
                    emit      = 1'b1;
                    emit_kind = (rx_sum_a_reg == sum_a_reg && b == sum_b_reg)
                                ? ubxfr_pkg::KIND_GOOD : ubxfr_pkg::KIND_BAD_SUM;
                end
                default: ;
            endcase
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= ubxfr_pkg::PH_HUNT1;
            header_count_reg  <= 2'd0;
            frame_class_reg   <= 8'd0;
            frame_id_reg      <= 8'd0;
            frame_length_reg  <= 16'd0;
            payload_count_reg <= 16'd0;
            sum_a_reg         <= 8'd0;
            sum_b_reg         <= 8'd0;
            rx_sum_a_reg      <= 8'd0;
        end else begin
            phase_reg         <= phase_next;
            header_count_reg  <= header_count_next;
            frame_class_reg   <= frame_class_next;
            frame_id_reg      <= frame_id_next;
            frame_length_reg  <= frame_length_next;
            payload_count_reg <= payload_count_next;
            sum_a_reg         <= sum_a_next;
            sum_b_reg         <= sum_b_next;
            rx_sum_a_reg      <= rx_sum_a_next;
        end
    end

    // Result register: holds a transaction until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit) begin
            out_kind_reg  <= emit_kind;
            out_data_reg  <= emit_data;
            out_class_reg <= frame_class_next;
            out_id_reg    <= frame_id_next;
            out_len_reg   <= frame_length_next;
            out_index_reg <= emit_index;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_kind          = out_kind_reg;
    assign m_data          = out_data_reg;
    assign m_msg_class     = out_class_reg;
    assign m_msg_id        = out_id_reg;
    assign m_payload_len   = out_len_reg;
    assign m_payload_index = out_index_reg;

    // Payload position always lies inside the announced length
    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_kind_reg == ubxfr_pkg::KIND_PAYLOAD)
            |-> (out_index_reg < out_len_reg))
        else $error("payload index beyond frame length");

    // Only payload results carry data or an index
    a_verdict_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_kind_reg != ubxfr_pkg::KIND_PAYLOAD)
            |-> (out_data_reg == 8'd0 && out_index_reg == 16'd0))
        else $error("verdict with nonzero data or index");

    // A processed payload byte always produces a result
    a_payload_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && phase_reg == ubxfr_pkg::PH_PAYLOAD) |=> out_valid_reg)
        else $error("payload byte lost");

    // Header counter is idle outside the header phase
    a_header_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != ubxfr_pkg::PH_HEADER) |-> (header_count_reg == 2'd0))
        else $error("header count active outside header");

endmodule

>>> hw/rtl/ubx_frame_receiver.sv
// UBX frame receiver top level; depends on ubxfr_pkg, ubxfr_regs, ubxfr_parser.
// Path: an accepted byte goes to the input register; its result, if any, then
// goes to the result register.
// Throughput: one byte per cycle; the input stalls only while a result waits on m_ready.
// Reset: synchronous active-low aresetn; hunt phase, sums cleared,
// registers back to 0xB5 / 0x62 / 512.
module ubx_frame_receiver (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ubxfr_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // Byte input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_rx_byte,
    // Results
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_kind,
    output logic [7:0]                        m_data,
    output logic [7:0]                        m_msg_class,
    output logic [7:0]                        m_msg_id,
    output logic [15:0]                       m_payload_len,
    output logic [15:0]                       m_payload_index
);

    ubxfr_pkg::cfg_t cfg;

    ubxfr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ubxfr_parser u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_data          (m_data),
        .m_msg_class     (m_msg_class),
        .m_msg_id        (m_msg_id),
        .m_payload_len   (m_payload_len),
        .m_payload_index (m_payload_index)
    );

endmodule
